// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules.
// Each macro checks on the rising edge of the given clock and is disabled
// while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
// The condition must never be true.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- rtl/ecpi_pkg.sv -----
`timescale 1ns / 1ps

package ecpi_pkg;

  // Width of the colors_used field.
  localparam int unsigned CU_W = 9;

  // Request action codes.
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_BUILD = 2'd1;
  localparam logic [1:0] ACT_MAP   = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] entry_number;
  } in_t;

  typedef struct packed {
    logic [7:0]      color_index;
    logic            added;
    logic            palette_full;
    logic [CU_W-1:0] colors_used;
    logic [7:0]      entry_red;
    logic [7:0]      entry_green;
    logic [7:0]      entry_blue;
  } out_t;

  // How much work a request needs.
  typedef enum logic [1:0] {
    K_DIRECT = 2'd0,
    K_SCAN   = 2'd1,
    K_READ   = 2'd2
  } kind_t;

  typedef struct packed {
    logic load;
    logic scan_en;
    logic rd_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    kind_t in_kind;
    logic  scan_done;
    logic  out_free;
  } sts_t;

endpackage

// ----- rtl/ecpi_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ecpi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output ecpi_pkg::cmd_t cmd,
  input  ecpi_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (sts.in_kind)
            ecpi_pkg::K_SCAN: state_nxt = S_SCAN;
            ecpi_pkg::K_READ: state_nxt = S_READ;
            default:          state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_NEXT(a_one_request, clk, rst_n, in_valid && in_ready, !in_ready,
    "a second request was taken before the first one finished")
  `ASSERT_NEXT(a_commit_to_idle, clk, rst_n, cmd.commit, in_ready,
    "controller did not return to idle after a result")

endmodule

// ----- rtl/ecpi_datapath.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ecpi_datapath #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ecpi_pkg::in_t   in_data,
  input  ecpi_pkg::cmd_t  cmd,
  output ecpi_pkg::sts_t  sts,
  output logic            out_valid,
  input  logic            out_ready,
  output ecpi_pkg::out_t  out_data
);

  localparam int unsigned CW = $clog2(PALETTE_ENTRIES + 1);
  localparam int unsigned AW = $clog2(PALETTE_ENTRIES - 1);
  localparam logic [CW-1:0] PE_C = CW'(PALETTE_ENTRIES);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  ecpi_pkg::in_t  req_r;
  ecpi_pkg::out_t out_data_r;
  ecpi_pkg::out_t res;
  logic           out_valid_r;
  logic [CW-1:0]  next_free_r;
  logic [CW-1:0]  iss_r;
  logic [CW-1:0]  cmp_idx_r;
  logic           cmp_vld_r;
  logic           hit_r;
  logic [CW-1:0]  hit_idx_r;
  logic [31:0]    mem_q_r;
  logic [31:0]    palette_mem [0:PALETTE_ENTRIES-2];

  logic [31:0]    key;
  logic           hit_now;
  logic           more;
  logic           issue;
  logic           entry_ok;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [CW-1:0]  nf_nxt;
  logic [CW-1:0]  idx;
  logic           add_now;
  ecpi_pkg::kind_t in_kind;
  logic           scan_done;
  logic           out_free;

  assign key = {req_r.alpha, req_r.blue, req_r.green, req_r.red};

  // Kind of the request offered at the input, for the controller's dispatch.
  always_comb begin
    case (in_data.action)
      ecpi_pkg::ACT_CLEAR: in_kind = ecpi_pkg::K_DIRECT;
      ecpi_pkg::ACT_BUILD,
      ecpi_pkg::ACT_MAP:   in_kind = (in_data.alpha != 8'd0) ? ecpi_pkg::K_SCAN
                                                             : ecpi_pkg::K_DIRECT;
      ecpi_pkg::ACT_READ:  in_kind = ecpi_pkg::K_READ;
      default:             in_kind = ecpi_pkg::K_DIRECT;
    endcase
  end

  // Scan: one entry is read per cycle, its compare happens in the next cycle.
  assign hit_now   = cmp_vld_r && (mem_q_r == key);
  assign more      = iss_r < next_free_r;
  assign issue     = cmd.scan_en && more && !hit_now;
  assign scan_done = hit_now || (!cmp_vld_r && !more);
  assign out_free  = !out_valid_r || out_ready;

  assign sts = {in_kind, scan_done, out_free};

  assign entry_ok = (req_r.entry_number != 8'd0) &&
                    (ecpi_pkg::CU_W'(req_r.entry_number) < ecpi_pkg::CU_W'(next_free_r));

  assign mem_re    = issue || (cmd.rd_en && entry_ok);
  assign mem_raddr = cmd.rd_en ? AW'(req_r.entry_number - 8'd1) : AW'(iss_r - ONE_C);
  assign mem_waddr = AW'(next_free_r - ONE_C);
  assign mem_we    = cmd.commit && add_now;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      palette_mem[mem_waddr] <= key;
    end
    if (mem_re) begin
      mem_q_r <= palette_mem[mem_raddr];
    end
  end

  // Result and next free index for the request being finished.
  always_comb begin
    nf_nxt  = next_free_r;
    idx     = '0;
    add_now = 1'b0;
    res     = '0;
    case (req_r.action)
      ecpi_pkg::ACT_CLEAR: begin
        nf_nxt = ONE_C;
      end
      ecpi_pkg::ACT_BUILD: begin
        if (req_r.alpha != 8'd0) begin
          if (hit_r) begin
            idx = hit_idx_r;
          end else if (next_free_r < PE_C) begin
            idx     = next_free_r;
            nf_nxt  = next_free_r + ONE_C;
            add_now = 1'b1;
          end
        end
      end
      ecpi_pkg::ACT_MAP: begin
        if (req_r.alpha != 8'd0 && hit_r) begin
          idx = hit_idx_r;
        end
      end
      ecpi_pkg::ACT_READ: begin
        if (entry_ok) begin
          res.entry_red   = mem_q_r[7:0];
          res.entry_green = mem_q_r[15:8];
          res.entry_blue  = mem_q_r[23:16];
        end
      end
      default: begin
        nf_nxt = next_free_r;
      end
    endcase
    res.color_index  = 8'(idx);
    res.added        = add_now;
    res.palette_full = nf_nxt >= PE_C;
    res.colors_used  = ecpi_pkg::CU_W'(nf_nxt);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (issue) begin
      cmp_idx_r <= iss_r;
    end
    if (hit_now) begin
      hit_idx_r <= cmp_idx_r;
    end
    if (cmd.commit) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r <= ONE_C;
      iss_r       <= ONE_C;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        iss_r     <= ONE_C;
        cmp_vld_r <= 1'b0;
        hit_r     <= 1'b0;
      end else if (cmd.scan_en) begin
        cmp_vld_r <= issue;
        if (issue) begin
          iss_r <= iss_r + ONE_C;
        end
        if (hit_now) begin
          hit_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        next_free_r <= nf_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEVER(a_next_free_range, clk, rst_n,
    (next_free_r == '0) || (next_free_r > PE_C),
    "next free index left its legal range")
  `ASSERT_NEVER(a_commit_blocked, clk, rst_n, cmd.commit && out_valid_r && !out_ready,
    "a result overwrote one that was still waiting")
  `ASSERT_NEXT(a_add_bumps_count, clk, rst_n, cmd.commit && add_now,
    next_free_r == $past(next_free_r) + ONE_C,
    "a stored color did not advance the next free index")
  `ASSERT_NEVER(a_scan_bound, clk, rst_n, iss_r > next_free_r,
    "scan pointer ran past the stored colors")

endmodule

// ----- rtl/exact_color_palette_indexer_unit.sv -----
`timescale 1ns / 1ps
// Exact color palette indexer.
// Requests arrive on the in_ channel (valid/ready) as one packed struct:
// clear, build from a pixel, map a pixel, or read one palette entry. Each
// request returns exactly one result on the out_ channel (valid/ready).
// Clear and a transparent pixel go straight to the result, an entry read
// takes one memory read, and build or map scan the colors held. The lookup
// walks the palette memory one entry per cycle through its single read port
// and stops early on a match. The block is ready for the next request in the
// cycle after the previous result enters the output register; it takes no
// new request while one is still in work.
// The next request is taken as soon as the previous one has finished its
// work, even if its result still waits in the output register; if the
// receiver stalls, the finished request waits and in_ready stays low.
// Reset (rst_n low at a clock edge) empties the palette, so the next free
// index is 1; the palette memory itself is not cleared, since entries at or
// above the next free index are never read.
module exact_color_palette_indexer_unit #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ecpi_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ecpi_pkg::out_t out_data
);

  // Commands from the controller and status back from the datapath.
  ecpi_pkg::cmd_t cmd;
  ecpi_pkg::sts_t sts;

  // The controller sequences each request: dispatch, palette scan or entry
  // read where needed, then hand-off into the output register once it is free.
  ecpi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // The datapath holds the palette memory, the next free index, the scan
  // pointers and the output register.
  ecpi_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- dv/exact_color_palette_indexer_unit_tb.sv -----
`timescale 1ns / 1ps

module exact_color_palette_indexer_unit_tb;

  // The block is checked at its full size: 255 colors plus transparent index 0.
  localparam int PAL_N = 256;
  // Number of colors in the pool that random pixels are mostly drawn from, so
  // that builds and maps often hit colors that are already held.
  localparam int POOL_N = 24;
  // Length of the long receiver hold-off, in cycles.
  localparam int HOLD_LEN = 400;
  // Cycles without any accepted request or result before the run is called hung.
  // The slowest request walks 255 entries, and the hold-off adds its own length.
  localparam int IDLE_LIMIT = 4000;
  // Cycles to wait after the last result, well above the longest latency.
  localparam int TAIL_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ecpi_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ecpi_pkg::out_t out_data;

  exact_color_palette_indexer_unit #(
    .PALETTE_ENTRIES(PAL_N)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // A 12 ns clock, high for half and low for half.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow palette that the testbench keeps for itself. Entry k holds the
  // RGBA key of index k, packed as {alpha, blue, green, red}.
  logic [31:0] pal_keys [1:PAL_N-1];
  logic [8:0]  pal_next_free = 9'd1;

  // Results that the block still owes, oldest first.
  ecpi_pkg::out_t pending_answers [$];

  logic [31:0] color_pool [POOL_N];

  // Pacing knobs, in percent of cycles.
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;

  // Each increment of hold_seq asks the receiver for one long hold-off.
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  int unsigned requests_sent = 0;
  int unsigned results_checked = 0;
  int unsigned colors_added = 0;
  int unsigned full_answers = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  // Computes the result of one request from the shadow palette and applies
  // the request to it. Index 0 is never handed out, and a full palette
  // ignores new colors.
  function automatic ecpi_pkg::out_t predict_palette_answer(ecpi_pkg::in_t r);
    ecpi_pkg::out_t ans;
    logic [31:0]    key;
    int             hit;
    int             i;
    ans = '0;
    key = {r.alpha, r.blue, r.green, r.red};
    hit = 0;
    case (r.action)
      ecpi_pkg::ACT_CLEAR: begin
        pal_next_free = 9'd1;
      end
      ecpi_pkg::ACT_BUILD, ecpi_pkg::ACT_MAP: begin
        // A transparent pixel is never looked up nor stored.
        if (r.alpha != 8'd0) begin
          for (i = 1; i < pal_next_free && i < PAL_N; i++) begin
            if (hit == 0 && pal_keys[i] == key) hit = i;
          end
          if (r.action == ecpi_pkg::ACT_BUILD && hit == 0 && pal_next_free < PAL_N) begin
            pal_keys[pal_next_free] = key;
            hit = pal_next_free;
            pal_next_free = pal_next_free + 9'd1;
            ans.added = 1'b1;
          end
        end
      end
      ecpi_pkg::ACT_READ: begin
        // Entry 0 and every entry that is not in use read as black.
        if (r.entry_number != 8'd0 && r.entry_number < pal_next_free) begin
          ans.entry_red   = pal_keys[r.entry_number][7:0];
          ans.entry_green = pal_keys[r.entry_number][15:8];
          ans.entry_blue  = pal_keys[r.entry_number][23:16];
        end
      end
      default: begin
        ans = '0;
      end
    endcase
    ans.color_index  = hit[7:0];
    ans.palette_full = (pal_next_free >= PAL_N);
    ans.colors_used  = pal_next_free;
    return ans;
  endfunction

  function automatic ecpi_pkg::in_t pix_req(logic [1:0] act, logic [7:0] red,
                                            logic [7:0] green, logic [7:0] blue,
                                            logic [7:0] alpha, logic [7:0] entry);
    ecpi_pkg::in_t r;
    r.action       = act;
    r.red          = red;
    r.green        = green;
    r.blue         = blue;
    r.alpha        = alpha;
    r.entry_number = entry;
    return r;
  endfunction

  function automatic ecpi_pkg::out_t answer(logic [7:0] idx, logic add, logic full,
                                            logic [8:0] used, logic [7:0] er,
                                            logic [7:0] eg, logic [7:0] eb);
    ecpi_pkg::out_t a;
    a.color_index  = idx;
    a.added        = add;
    a.palette_full = full;
    a.colors_used  = used;
    a.entry_red    = er;
    a.entry_green  = eg;
    a.entry_blue   = eb;
    return a;
  endfunction

  // Random request: mostly builds and maps of pool colors with some fresh
  // colors, some transparent pixels, reads that usually land on a used
  // entry, and an occasional clear that keeps the palette small.
  function automatic ecpi_pkg::in_t random_request();
    ecpi_pkg::in_t r;
    int unsigned   pick;
    logic [31:0]   key;
    pick = $urandom_range(99);
    if (pick < 4) r.action = ecpi_pkg::ACT_CLEAR;
    else if (pick < 49) r.action = ecpi_pkg::ACT_BUILD;
    else if (pick < 79) r.action = ecpi_pkg::ACT_MAP;
    else r.action = ecpi_pkg::ACT_READ;
    if ($urandom_range(99) < 65) key = color_pool[$urandom_range(POOL_N-1)];
    else key = $urandom;
    if ($urandom_range(99) < 8) key[31:24] = 8'h00;
    {r.alpha, r.blue, r.green, r.red} = key;
    r.entry_number = 8'($urandom_range(255));
    if (r.action == ecpi_pkg::ACT_READ && $urandom_range(99) < 70) begin
      r.entry_number = 8'($urandom_range(pal_next_free));
    end
    if ($urandom_range(99) < 3) color_pool[$urandom_range(POOL_N-1)] = $urandom;
    return r;
  endfunction

  // Offers one request, holding it until the block takes it. The expected
  // result is either the one typed into the directed table or the predicted
  // one; the shadow palette is updated in both cases.
  task automatic offer_request(input ecpi_pkg::in_t r, input bit typed,
                               input ecpi_pkg::out_t want);
    ecpi_pkg::out_t ans;
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    ans = predict_palette_answer(r);
    if (ans.added) colors_added++;
    if (ans.palette_full) full_answers++;
    pending_answers.push_back(typed ? want : ans);
    requests_sent++;
  endtask

  // The sender goes quiet until the block has returned every result owed.
  // The task always waits for a clock edge after valid drops, so the next
  // request never raises valid in the same step.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  task automatic note_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("MISMATCH at %0t result %0d: %s expected 0x%0h got 0x%0h",
                 $realtime, results_checked, name, want, got);
      end
    end
  endtask

  // Receiver pacing. A requested hold-off keeps ready low until HOLD_LEN has
  // counted down; otherwise ready drops at random at the current stall rate.
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (out_stall_pct != 0 && $urandom_range(99) < out_stall_pct) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every accepted result is compared with the oldest one still owed.
  always @(posedge clk) begin
    ecpi_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("MISMATCH at %0t: result 0x%0h arrived with none owed", $realtime, out_data);
        end
      end else begin
        want = pending_answers.pop_front();
        note_field("color_index", want.color_index, out_data.color_index);
        note_field("added", want.added, out_data.added);
        note_field("palette_full", want.palette_full, out_data.palette_full);
        note_field("colors_used", want.colors_used, out_data.colors_used);
        note_field("entry_red", want.entry_red, out_data.entry_red);
        note_field("entry_green", want.entry_green, out_data.entry_green);
        note_field("entry_blue", want.entry_blue, out_data.entry_blue);
      end
      results_checked++;
    end
  end

  // Watchdog: a run in which nothing moves for too long is a hang.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles, %0d results still owed",
               idle_cycles, pending_answers.size());
      $display("exact_color_palette_indexer_unit test failed");
      $finish;
    end
  end

  typedef struct {
    ecpi_pkg::in_t  req;
    bit             typed;
    ecpi_pkg::out_t want;
  } row_t;

  initial begin
    row_t rows [$];
    int   k;
    int   phase;

    for (k = 0; k < POOL_N; k++) color_pool[k] = $urandom;

    // Directed table. Typed answers are the ones obvious from the behavior;
    // rows with typed cleared are checked against the predictor.
    rows.push_back('{pix_req(ecpi_pkg::ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
                     answer(8'd0, 1'b0, 1'b0, 9'd1, 8'h00, 8'h00, 8'h00)});
    // Transparent pixels are neither found nor stored.
    rows.push_back('{pix_req(ecpi_pkg::ACT_MAP, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00), 1'b1,
                     answer(8'd0, 1'b0, 1'b0, 9'd1, 8'h00, 8'h00, 8'h00)});
    rows.push_back('{pix_req(ecpi_pkg::ACT_BUILD, 8'hff, 8'hff, 8'hff, 8'h00, 8'hff), 1'b1,
                     answer(8'd0, 1'b0, 1'b0, 9'd1, 8'h00, 8'h00, 8'h00)});
    rows.push_back('{pix_req(ecpi_pkg::ACT_BUILD, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00), 1'b1,
                     answer(8'd1, 1'b1, 1'b0, 9'd2, 8'h00, 8'h00, 8'h00)});
    rows.push_back('{pix_req(ecpi_pkg::ACT_BUILD, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00), 1'b1,
                     answer(8'd2, 1'b1, 1'b0, 9'd3, 8'h00, 8'h00, 8'h00)});
    // A known color returns its index without being stored again.
    rows.push_back('{pix_req(ecpi_pkg::ACT_BUILD, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00), 1'b1,
                     answer(8'd1, 1'b0, 1'b0, 9'd3, 8'h00, 8'h00, 8'h00)});
    // Same RGB with another alpha is a different color.
    rows.push_back('{pix_req(ecpi_pkg::ACT_BUILD, 8'hff, 8'hff, 8'hff, 8'hfe, 8'h00), 1'b1,
                     answer(8'd3, 1'b1, 1'b0, 9'd4, 8'h00, 8'h00, 8'h00)});
    rows.push_back('{pix_req(ecpi_pkg::ACT_MAP, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00), 1'b1,
                     answer(8'd1, 1'b0, 1'b0, 9'd4, 8'h00, 8'h00, 8'h00)});
    rows.push_back('{pix_req(ecpi_pkg::ACT_MAP, 8'hff, 8'hff, 8'hff, 8'hfe, 8'h00), 1'b1,
                     answer(8'd3, 1'b0, 1'b0, 9'd4, 8'h00, 8'h00, 8'h00)});
    rows.push_back('{pix_req(ecpi_pkg::ACT_MAP, 8'h12, 8'h34, 8'h56, 8'h78, 8'h00), 1'b1,
                     answer(8'd0, 1'b0, 1'b0, 9'd4, 8'h00, 8'h00, 8'h00)});
    rows.push_back('{pix_req(ecpi_pkg::ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01), 1'b1,
                     answer(8'd0, 1'b0, 1'b0, 9'd4, 8'hff, 8'hff, 8'hff)});
    rows.push_back('{pix_req(ecpi_pkg::ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02), 1'b1,
                     answer(8'd0, 1'b0, 1'b0, 9'd4, 8'h00, 8'h00, 8'h00)});
    rows.push_back('{pix_req(ecpi_pkg::ACT_READ, 8'hff, 8'hff, 8'hff, 8'hff, 8'h03), 1'b1,
                     answer(8'd0, 1'b0, 1'b0, 9'd4, 8'hff, 8'hff, 8'hff)});
    // Entries at or above the next free index read as black.
    rows.push_back('{pix_req(ecpi_pkg::ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04), 1'b1,
                     answer(8'd0, 1'b0, 1'b0, 9'd4, 8'h00, 8'h00, 8'h00)});
    rows.push_back('{pix_req(ecpi_pkg::ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff), 1'b1,
                     answer(8'd0, 1'b0, 1'b0, 9'd4, 8'h00, 8'h00, 8'h00)});
    rows.push_back('{pix_req(ecpi_pkg::ACT_BUILD, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff),
                     1'b0, '0});
    rows.push_back('{pix_req(ecpi_pkg::ACT_READ, 8'ha5, 8'h5a, 8'hc3, 8'h3c, 8'h04),
                     1'b0, '0});
    // Clear ignores every field and empties the palette.
    rows.push_back('{pix_req(ecpi_pkg::ACT_CLEAR, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff), 1'b1,
                     answer(8'd0, 1'b0, 1'b0, 9'd1, 8'h00, 8'h00, 8'h00)});
    rows.push_back('{pix_req(ecpi_pkg::ACT_MAP, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00), 1'b1,
                     answer(8'd0, 1'b0, 1'b0, 9'd1, 8'h00, 8'h00, 8'h00)});
    rows.push_back('{pix_req(ecpi_pkg::ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01), 1'b1,
                     answer(8'd0, 1'b0, 1'b0, 9'd1, 8'h00, 8'h00, 8'h00)});
    rows.push_back('{pix_req(ecpi_pkg::ACT_BUILD, 8'h80, 8'h40, 8'h20, 8'h10, 8'h00), 1'b1,
                     answer(8'd1, 1'b1, 1'b0, 9'd2, 8'h00, 8'h00, 8'h00)});
    rows.push_back('{pix_req(ecpi_pkg::ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01), 1'b1,
                     answer(8'd0, 1'b0, 1'b0, 9'd2, 8'h80, 8'h40, 8'h20)});
    rows.push_back('{pix_req(ecpi_pkg::ACT_BUILD, 8'ha5, 8'h5a, 8'hc3, 8'h3c, 8'h55),
                     1'b0, '0});
    rows.push_back('{pix_req(ecpi_pkg::ACT_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                     1'b0, '0});

    // Synchronous reset, held low from the start and released once.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) offer_request(rows[i].req, rows[i].typed, rows[i].want);
    drain_results();

    // Fill the palette to capacity with distinct colors, then keep offering
    // new ones, which a full palette must ignore.
    for (k = 0; k < 260; k++) begin
      offer_request(pix_req(ecpi_pkg::ACT_BUILD, 8'(k), {7'd0, k[8]}, 8'h3c, 8'hff, 8'(k)),
                    1'b0, '0);
    end
    offer_request(pix_req(ecpi_pkg::ACT_MAP, 8'd0, 8'd0, 8'h3c, 8'hff, 8'd0), 1'b0, '0);
    offer_request(pix_req(ecpi_pkg::ACT_MAP, 8'd254, 8'd0, 8'h3c, 8'hff, 8'd0), 1'b0, '0);
    offer_request(pix_req(ecpi_pkg::ACT_MAP, 8'd255, 8'd0, 8'h3c, 8'hff, 8'd0), 1'b0, '0);
    offer_request(pix_req(ecpi_pkg::ACT_BUILD, 8'd7, 8'd0, 8'h3c, 8'hff, 8'd0), 1'b0, '0);
    offer_request(pix_req(ecpi_pkg::ACT_BUILD, 8'd7, 8'd0, 8'h3c, 8'h00, 8'd0), 1'b0, '0);
    offer_request(pix_req(ecpi_pkg::ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255), 1'b0, '0);
    offer_request(pix_req(ecpi_pkg::ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0, '0);

    // Long receiver hold-off against a full palette: the block finishes what
    // it can, then must stall its input while the sender keeps offering.
    hold_seq++;
    for (k = 0; k < 12; k++) offer_request(random_request(), 1'b0, '0);
    drain_results();
    offer_request(pix_req(ecpi_pkg::ACT_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0, '0);
    drain_results();

    // Random traffic under four pacing modes.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 57; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 57; end
        default: begin in_idle_pct = 22; out_stall_pct = 22; end
      endcase
      for (k = 0; k < 175; k++) begin
        if (phase == 1 && k == 120) hold_seq++;
        offer_request(random_request(), 1'b0, '0);
      end
      drain_results();
    end

    out_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Summary: %0d requests, %0d results checked, %0d new colors stored,",
             requests_sent, results_checked, colors_added);
    $display("  %0d answers with a full palette, under four pacing modes and two long holds.",
             full_answers);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("exact_color_palette_indexer_unit test passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, pending_answers.size());
      $display("exact_color_palette_indexer_unit test failed");
    end
    $finish;
  end

endmodule
